FILE: design/jcpl_pkg.sv
// ----------------------------------------------------------------------------
// jcpl_pkg
// Shared types, constants and helpers for the JC69 partial likelihood block.
// ----------------------------------------------------------------------------
`default_nettype none

package jcpl_pkg;

    localparam int FRAC_BITS = 31;
    localparam int NSTATES   = 4;
    localparam int DATA_W    = 32;
    localparam int MASK_W    = NSTATES;
    localparam int PROD_W    = 2 * DATA_W - FRAC_BITS;
    // wide enough for four truncated products or four tip coefficients
    localparam int SUM_W     = ((PROD_W > DATA_W) ? PROD_W : DATA_W) + 2;
    localparam int CFG_IDX_W = 3;

    localparam logic [DATA_W-1:0] SAT_VALUE =
        (FRAC_BITS < DATA_W) ? DATA_W'(64'd1 << FRAC_BITS) : {DATA_W{1'b1}};

    // 1.0 as seen through the 32-bit register
    localparam logic [DATA_W-1:0] MATCH_RESET = DATA_W'(64'd1 << FRAC_BITS);

    localparam logic [CFG_IDX_W-1:0] REG_LEFT_MATCH     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LEFT_MISMATCH  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_RIGHT_MATCH    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_RIGHT_MISMATCH = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_LEFT_IS_TIP    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_RIGHT_IS_TIP   = 3'd5;

    typedef logic [DATA_W-1:0] vec_t [NSTATES];

    typedef struct packed {
        logic s1;
        logic s2;
    } pipe_en_t;

    function automatic logic [DATA_W-1:0] sat_clamp(input logic [SUM_W-1:0] x);
        logic [DATA_W-1:0] r;
        if (x > SUM_W'(SAT_VALUE))
            r = SAT_VALUE;
        else
            r = x[DATA_W-1:0];
        return r;
    endfunction

endpackage

`default_nettype wire

FILE: design/jc69_partial_likelihood_site.sv
// ----------------------------------------------------------------------------
// jc69_partial_likelihood_site
// Per-site parent likelihood vector from two children under JC69.
//
// Usage:
//   Input channel (in_valid/in_stall) carries one site: masks, both child
//   vectors and last_site. Output channel (out_valid/out_stall) returns the
//   parent vector out_v0..out_v3 and out_last for that site, in order.
//   Config registers are written through cfg_wr_en/cfg_index/cfg_data while
//   no transaction is in flight; unknown indexes are ignored.
//   Pipeline: an accepted site passes through three register stages in
//   order (child products, row terms with saturation, term product into
//   the output register) before out_valid rises. Throughput: one site
//   per cycle while out_stall is low.
//   Reset: pipeline empties, a = 1.0, b = 0, both sides inner nodes.
//   Stall: each stage holds while the stage after it is full and blocked;
//   empty stages still fill, so in_stall rises only once all three stages
//   hold a transaction and out_stall is high.
// ----------------------------------------------------------------------------
`default_nettype none

module jc69_partial_likelihood_site (
    input  wire logic                                clk,
    input  wire logic                                rst_n,

    input  wire logic                                cfg_wr_en,
    input  wire logic [jcpl_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  wire logic [jcpl_pkg::DATA_W-1:0]         cfg_data,

    input  wire logic                                in_valid,
    output logic                                     in_stall,
    input  wire logic [jcpl_pkg::MASK_W-1:0]         left_mask,
    input  wire logic [jcpl_pkg::MASK_W-1:0]         right_mask,
    input  wire logic [jcpl_pkg::DATA_W-1:0]         left_v0,
    input  wire logic [jcpl_pkg::DATA_W-1:0]         left_v1,
    input  wire logic [jcpl_pkg::DATA_W-1:0]         left_v2,
    input  wire logic [jcpl_pkg::DATA_W-1:0]         left_v3,
    input  wire logic [jcpl_pkg::DATA_W-1:0]         right_v0,
    input  wire logic [jcpl_pkg::DATA_W-1:0]         right_v1,
    input  wire logic [jcpl_pkg::DATA_W-1:0]         right_v2,
    input  wire logic [jcpl_pkg::DATA_W-1:0]         right_v3,
    input  wire logic                                last_site,

    output logic                                     out_valid,
    input  wire logic                                out_stall,
    output logic [jcpl_pkg::DATA_W-1:0]              out_v0,
    output logic [jcpl_pkg::DATA_W-1:0]              out_v1,
    output logic [jcpl_pkg::DATA_W-1:0]              out_v2,
    output logic [jcpl_pkg::DATA_W-1:0]              out_v3,
    output logic                                     out_last
);

    logic [jcpl_pkg::DATA_W-1:0] left_match_reg;
    logic [jcpl_pkg::DATA_W-1:0] left_mismatch_reg;
    logic [jcpl_pkg::DATA_W-1:0] right_match_reg;
    logic [jcpl_pkg::DATA_W-1:0] right_mismatch_reg;
    logic                        left_is_tip_reg;
    logic                        right_is_tip_reg;

    logic                        v1_reg, v2_reg, v3_reg;
    logic                        last1_reg, last2_reg, last3_reg;
    logic                        ready1, ready2, ready3;
    jcpl_pkg::pipe_en_t          en;

    jcpl_pkg::vec_t              left_v, right_v;
    jcpl_pkg::vec_t              left_term, right_term;
    logic [2*jcpl_pkg::DATA_W-1:0] mul_out [jcpl_pkg::NSTATES];
    jcpl_pkg::vec_t              out_next;
    jcpl_pkg::vec_t              out_reg;

    // configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            left_match_reg     <= jcpl_pkg::MATCH_RESET;
            left_mismatch_reg  <= '0;
            right_match_reg    <= jcpl_pkg::MATCH_RESET;
            right_mismatch_reg <= '0;
            left_is_tip_reg    <= 1'b0;
            right_is_tip_reg   <= 1'b0;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                jcpl_pkg::REG_LEFT_MATCH:     left_match_reg     <= cfg_data;
                jcpl_pkg::REG_LEFT_MISMATCH:  left_mismatch_reg  <= cfg_data;
                jcpl_pkg::REG_RIGHT_MATCH:    right_match_reg    <= cfg_data;
                jcpl_pkg::REG_RIGHT_MISMATCH: right_mismatch_reg <= cfg_data;
                jcpl_pkg::REG_LEFT_IS_TIP:    left_is_tip_reg    <= cfg_data[0];
                jcpl_pkg::REG_RIGHT_IS_TIP:   right_is_tip_reg   <= cfg_data[0];
                default: ;
            endcase
        end
    end

    // per-stage flow control
    assign ready3   = !v3_reg || !out_stall;
    assign ready2   = !v2_reg || ready3;
    assign ready1   = !v1_reg || ready2;
    assign in_stall = !ready1;
    assign en.s1    = ready1;
    assign en.s2    = ready2;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            if (ready1)
                v1_reg <= in_valid;
            if (ready2)
                v2_reg <= v1_reg;
            if (ready3)
                v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ready1)
            last1_reg <= last_site;
        if (ready2)
            last2_reg <= last1_reg;
        if (ready3)
            last3_reg <= last2_reg;
    end

    always_comb
    begin
        left_v[0]  = left_v0;
        left_v[1]  = left_v1;
        left_v[2]  = left_v2;
        left_v[3]  = left_v3;
        right_v[0] = right_v0;
        right_v[1] = right_v1;
        right_v[2] = right_v2;
        right_v[3] = right_v3;
    end

    jcpl_side u_left (
        .clk           (clk),
        .en            (en),
        .match_coef    (left_match_reg),
        .mismatch_coef (left_mismatch_reg),
        .is_tip        (left_is_tip_reg),
        .mask          (left_mask),
        .v             (left_v),
        .term          (left_term)
    );

    jcpl_side u_right (
        .clk           (clk),
        .en            (en),
        .match_coef    (right_match_reg),
        .mismatch_coef (right_mismatch_reg),
        .is_tip        (right_is_tip_reg),
        .mask          (right_mask),
        .v             (right_v),
        .term          (right_term)
    );

    // parent term product, truncated and saturated
    always_comb
    begin
        for (int i = 0; i < jcpl_pkg::NSTATES; i++)
        begin
            mul_out[i]  = (2*jcpl_pkg::DATA_W)'(left_term[i])
                        * (2*jcpl_pkg::DATA_W)'(right_term[i]);
            out_next[i] = jcpl_pkg::sat_clamp(
                jcpl_pkg::SUM_W'(mul_out[i] >> jcpl_pkg::FRAC_BITS));
        end
    end

    always_ff @(posedge clk)
    begin
        if (ready3)
            out_reg <= out_next;
    end

    assign out_valid = v3_reg;
    assign out_v0    = out_reg[0];
    assign out_v1    = out_reg[1];
    assign out_v2    = out_reg[2];
    assign out_v3    = out_reg[3];
    assign out_last  = last3_reg;

`ifndef SYNTHESIS
    a_accept_fills_s1: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> v1_reg)
        else $error("accepted transaction did not enter stage 1");

    a_s1_held: assert property (@(posedge clk) disable iff (!rst_n)
        (v1_reg && !ready2) |=> v1_reg)
        else $error("stage 1 transaction lost while blocked");

    a_s2_held: assert property (@(posedge clk) disable iff (!rst_n)
        (v2_reg && !ready3) |=> (v2_reg && $stable(last2_reg)))
        else $error("stage 2 transaction lost while blocked");

    a_out_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (out_v0 <= jcpl_pkg::SAT_VALUE && out_v1 <= jcpl_pkg::SAT_VALUE
                    && out_v2 <= jcpl_pkg::SAT_VALUE && out_v3 <= jcpl_pkg::SAT_VALUE))
        else $error("output likelihood above saturation value");
`endif

endmodule

`default_nettype wire

FILE: design/jcpl_side.sv
// ----------------------------------------------------------------------------
// jcpl_side
// One child's four JC69 row terms: products in the first stage, sums,
// tip selection and saturation in the second.
// ----------------------------------------------------------------------------
`default_nettype none

module jcpl_side (
    input  wire logic                              clk,
    input  wire jcpl_pkg::pipe_en_t                en,
    input  wire logic [jcpl_pkg::DATA_W-1:0]       match_coef,
    input  wire logic [jcpl_pkg::DATA_W-1:0]       mismatch_coef,
    input  wire logic                              is_tip,
    input  wire logic [jcpl_pkg::MASK_W-1:0]       mask,
    input  wire jcpl_pkg::vec_t                    v,
    output jcpl_pkg::vec_t                         term
);

    logic [2*jcpl_pkg::DATA_W-1:0] mul_a [jcpl_pkg::NSTATES];
    logic [2*jcpl_pkg::DATA_W-1:0] mul_b [jcpl_pkg::NSTATES];

    logic [jcpl_pkg::PROD_W-1:0]   prod_a_reg [jcpl_pkg::NSTATES];
    logic [jcpl_pkg::PROD_W-1:0]   prod_b_reg [jcpl_pkg::NSTATES];
    logic [jcpl_pkg::MASK_W-1:0]   mask_reg;

    logic [jcpl_pkg::SUM_W-1:0]    sum_b;
    logic [jcpl_pkg::SUM_W-1:0]    inner_sum [jcpl_pkg::NSTATES];
    logic [jcpl_pkg::SUM_W-1:0]    tip_sum   [jcpl_pkg::NSTATES];
    jcpl_pkg::vec_t                term_next;
    jcpl_pkg::vec_t                term_reg;

    always_comb
    begin
        for (int j = 0; j < jcpl_pkg::NSTATES; j++)
        begin
            mul_a[j] = (2*jcpl_pkg::DATA_W)'(match_coef) * (2*jcpl_pkg::DATA_W)'(v[j]);
            mul_b[j] = (2*jcpl_pkg::DATA_W)'(mismatch_coef) * (2*jcpl_pkg::DATA_W)'(v[j]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en.s1)
        begin
            for (int j = 0; j < jcpl_pkg::NSTATES; j++)
            begin
                prod_a_reg[j] <= jcpl_pkg::PROD_W'(mul_a[j] >> jcpl_pkg::FRAC_BITS);
                prod_b_reg[j] <= jcpl_pkg::PROD_W'(mul_b[j] >> jcpl_pkg::FRAC_BITS);
            end
            mask_reg <= mask;
        end
    end

    // inner term: a*v_i + b*(sum of the other v_j), each product truncated
    always_comb
    begin
        sum_b = '0;
        for (int j = 0; j < jcpl_pkg::NSTATES; j++)
            sum_b = sum_b + jcpl_pkg::SUM_W'(prod_b_reg[j]);
        for (int i = 0; i < jcpl_pkg::NSTATES; i++)
        begin
            inner_sum[i] = sum_b - jcpl_pkg::SUM_W'(prod_b_reg[i])
                         + jcpl_pkg::SUM_W'(prod_a_reg[i]);
            tip_sum[i] = '0;
            for (int j = 0; j < jcpl_pkg::NSTATES; j++)
            begin
                if (mask_reg[j])
                    tip_sum[i] = tip_sum[i] + ((i == j) ? jcpl_pkg::SUM_W'(match_coef)
                                                        : jcpl_pkg::SUM_W'(mismatch_coef));
            end
            term_next[i] = jcpl_pkg::sat_clamp(is_tip ? tip_sum[i] : inner_sum[i]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en.s2)
            term_reg <= term_next;
    end

    assign term = term_reg;

endmodule

`default_nettype wire
